// ----- rtl/urb_pkg.sv -----
package urb_pkg;

    localparam int unsigned REG_COUNT = 11;
    localparam int unsigned IX_W      = 4;

    localparam logic [IX_W-1:0] IX_CON   = 4'd1;
    localparam logic [IX_W-1:0] IX_MCON  = 4'd3;
    localparam logic [IX_W-1:0] IX_STAT  = 4'd4;
    localparam logic [IX_W-1:0] IX_MSTAT = 4'd7;
    localparam logic [IX_W-1:0] IX_TX    = 4'd8;
    localparam logic [IX_W-1:0] IX_RX    = 4'd9;

    localparam logic [31:0] STATUS_RESET = 32'h0000_0006;

    localparam int unsigned LOOPBACK_BIT = 5;
    localparam int unsigned RX_LEVEL_BIT = 8;
    localparam int unsigned TX_LEVEL_BIT = 9;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_DEASSERT = 2'd1,
        EV_PULSE    = 2'd2,
        EV_LEVEL    = 2'd3
    } int_ev_t;

    typedef enum logic {
        ACT_READ  = 1'b0,
        ACT_WRITE = 1'b1
    } action_t;

    typedef struct packed {
        logic        action;
        logic [13:0] reg_offset;
        logic [31:0] write_data;
    } req_item_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        bad_offset;
        logic [1:0]  tx_int_event;
        logic [1:0]  rx_int_event;
    } rsp_item_t;

    typedef enum logic {
        ST_EMPTY = 1'b0,
        ST_FULL  = 1'b1
    } ctl_state_t;

    typedef struct packed {
        logic exec;
        logic cfg_wr;
    } urb_cmd_t;

endpackage

// ----- rtl/uart_register_block.sv -----
// UART control/status register block.
// req channel: one bus access per request (action 0 read, 1 write),
// byte offset and write word. rsp channel: read data, bad offset flag
// and transmit/receive interrupt effects, one response per request.
// cfg channel: one bit, selects the third channel (no modem registers,
// transmit always loops back); always ready, write only while idle.
// The response is valid the cycle after the request is taken.
// Throughput: one request per cycle unless stalled; the whole access is
// one register bank read-modify-write feeding a single output register.
// When the receiver stalls, the output register holds its response and
// req_ready drops until it is taken; a request is taken in the same
// cycle that the pending response leaves.
// Reset: status register reads 6, all other registers and the channel
// select read 0, no response pending. Ready right after reset.
module uart_register_block
    import urb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_item_t rsp,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic      cfg_data
);

    urb_cmd_t cmd;

    urb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cmd       (cmd)
    );

    urb_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .req      (req),
        .cfg_data (cfg_data),
        .rsp      (rsp)
    );

endmodule

// ----- rtl/urb_ctrl.sv -----
module urb_ctrl
    import urb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    input  logic     cfg_valid,
    output logic     cfg_ready,
    output urb_cmd_t cmd
);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_EMPTY;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_EMPTY:
            begin
                if (req_valid)
                begin
                    state_next = ST_FULL;
                end
            end
            ST_FULL:
            begin
                // a response taken while a new request arrives keeps us full
                if (rsp_ready && !req_valid)
                begin
                    state_next = ST_EMPTY;
                end
            end
            default:
            begin
                state_next = ST_EMPTY;
            end
        endcase
    end

    always_comb
    begin
        req_ready  = 1'b0;
        rsp_valid  = 1'b0;
        case (state_reg)
            ST_EMPTY:
            begin
                req_ready = 1'b1;
            end
            ST_FULL:
            begin
                rsp_valid = 1'b1;
                req_ready = rsp_ready;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
        cfg_ready  = 1'b1;
        cmd.exec   = req_valid && req_ready;
        cmd.cfg_wr = cfg_valid;
    end

endmodule

// ----- rtl/urb_datapath.sv -----
module urb_datapath
    import urb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  urb_cmd_t  cmd,
    input  req_item_t req,
    input  logic      cfg_data,
    output rsp_item_t rsp
);

    logic [31:0] bank_reg  [REG_COUNT];
    logic [31:0] bank_next [REG_COUNT];
    logic        third_reg;
    rsp_item_t   rsp_reg;
    rsp_item_t   rsp_next;

    logic [IX_W-1:0] rix;
    logic            bad;
    logic            loop;
    logic [31:0]     con;

    assign rix  = req.reg_offset[IX_W+1:2];
    assign con  = bank_reg[IX_CON];
    assign loop = con[LOOPBACK_BIT] || third_reg;

    always_comb
    begin
        bad = 1'b0;
        if (req.reg_offset[1:0] != 2'b00 || req.reg_offset[13:2] >= 12'(REG_COUNT))
        begin
            bad = 1'b1;
        end
        else if (third_reg && (rix == IX_MCON || rix == IX_MSTAT))
        begin
            bad = 1'b1;
        end
    end

    always_comb
    begin
        for (int k = 0; k < REG_COUNT; k++)
        begin
            bank_next[k] = bank_reg[k];
        end
        rsp_next.read_data    = 32'hffff_ffff;
        rsp_next.bad_offset   = 1'b1;
        rsp_next.tx_int_event = EV_NONE;
        rsp_next.rx_int_event = EV_NONE;
        if (!bad)
        begin
            rsp_next.bad_offset = 1'b0;
            if (req.action == ACT_READ)
            begin
                rsp_next.read_data = bank_reg[rix];
                if (rix == IX_RX)
                begin
                    bank_next[IX_STAT][0] = 1'b0;
                    if (con[RX_LEVEL_BIT])
                    begin
                        rsp_next.rx_int_event = EV_DEASSERT;
                    end
                end
            end
            else
            begin
                rsp_next.read_data = 32'h0;
                bank_next[rix]     = req.write_data;
                if (rix == IX_CON)
                begin
                    if (req.write_data[TX_LEVEL_BIT])
                    begin
                        rsp_next.tx_int_event = EV_LEVEL;
                    end
                    if (req.write_data[RX_LEVEL_BIT])
                    begin
                        rsp_next.rx_int_event = EV_DEASSERT;
                    end
                end
                else if (rix == IX_TX)
                begin
                    bank_next[IX_STAT][2:1] = 2'b11;
                    rsp_next.tx_int_event   = con[TX_LEVEL_BIT] ? EV_LEVEL : EV_PULSE;
                    if (loop)
                    begin
                        bank_next[IX_RX]      = req.write_data;
                        bank_next[IX_STAT][0] = 1'b1;
                        rsp_next.rx_int_event = con[RX_LEVEL_BIT] ? EV_LEVEL : EV_PULSE;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < REG_COUNT; k++)
            begin
                bank_reg[k] <= (k == int'(IX_STAT)) ? STATUS_RESET : 32'h0;
            end
            third_reg <= 1'b0;
        end
        else
        begin
            if (cmd.exec)
            begin
                for (int k = 0; k < REG_COUNT; k++)
                begin
                    bank_reg[k] <= bank_next[k];
                end
            end
            if (cmd.cfg_wr)
            begin
                third_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

    a_rx_read_clears_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && req.action == ACT_READ && !bad && rix == IX_RX
        |=> !bank_reg[IX_STAT][0])
        else $error("receive read left receive-ready set");

    a_bad_no_effect: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && bad
        |=> rsp_reg.read_data == 32'hffff_ffff && rsp_reg.rx_int_event == EV_NONE
            && $stable(bank_reg[IX_STAT]))
        else $error("bad offset request changed state or response");

    a_loopback_copy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && req.action == ACT_WRITE && !bad && rix == IX_TX && loop
        |=> bank_reg[IX_STAT][2:0] == 3'b111 && bank_reg[IX_RX] == $past(req.write_data))
        else $error("loopback transmit write not copied to receive");

endmodule

// ----- sim/tb_top.sv -----
module tb_top;
    import urb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned PHASE_ITEMS    = 110;

    typedef enum logic {
        ROW_ACCESS = 1'b0,
        ROW_CFG    = 1'b1
    } row_kind_t;

    typedef struct packed {
        row_kind_t kind;
        logic      cfg_val;
        logic      pinned;
        req_item_t acc;
        rsp_item_t want;
    } plan_row_t;

    localparam rsp_item_t RSP_BAD = '{32'hffff_ffff, 1'b1, EV_NONE, EV_NONE};

    // Pinned rows carry their own expected response; the rest use the predictor.
    localparam plan_row_t PLAN [27] = '{
        '{ROW_ACCESS, 1'b0, 1'b1, '{ACT_READ,  14'h0010, 32'h0},
          '{32'h0000_0006, 1'b0, EV_NONE, EV_NONE}},
        '{ROW_ACCESS, 1'b0, 1'b1, '{ACT_READ,  14'h0000, 32'hffff_ffff},
          '{32'h0, 1'b0, EV_NONE, EV_NONE}},
        '{ROW_ACCESS, 1'b0, 1'b1, '{ACT_READ,  14'h0028, 32'h0},
          '{32'h0, 1'b0, EV_NONE, EV_NONE}},
        '{ROW_ACCESS, 1'b0, 1'b1, '{ACT_READ,  14'h002c, 32'h0}, RSP_BAD},
        '{ROW_ACCESS, 1'b0, 1'b1, '{ACT_READ,  14'h3fff, 32'h0}, RSP_BAD},
        '{ROW_ACCESS, 1'b0, 1'b1, '{ACT_WRITE, 14'h3ffc, 32'hffff_ffff}, RSP_BAD},
        '{ROW_ACCESS, 1'b0, 1'b1, '{ACT_WRITE, 14'h0002, 32'hffff_ffff}, RSP_BAD},
        '{ROW_ACCESS, 1'b0, 1'b1, '{ACT_WRITE, 14'h0000, 32'hffff_ffff},
          '{32'h0, 1'b0, EV_NONE, EV_NONE}},
        '{ROW_ACCESS, 1'b0, 1'b1, '{ACT_READ,  14'h0000, 32'h0},
          '{32'hffff_ffff, 1'b0, EV_NONE, EV_NONE}},
        // control word with both level bits
        '{ROW_ACCESS, 1'b0, 1'b1, '{ACT_WRITE, 14'h0004, 32'h0000_0300},
          '{32'h0, 1'b0, EV_LEVEL, EV_DEASSERT}},
        '{ROW_ACCESS, 1'b0, 1'b0, '{ACT_WRITE, 14'h0020, 32'h0000_00a5}, '0},
        '{ROW_ACCESS, 1'b0, 1'b0, '{ACT_READ,  14'h0024, 32'h0}, '0},
        // loopback, pulse mode
        '{ROW_ACCESS, 1'b0, 1'b0, '{ACT_WRITE, 14'h0004, 32'h0000_0020}, '0},
        '{ROW_ACCESS, 1'b0, 1'b0, '{ACT_WRITE, 14'h0020, 32'h0000_005a}, '0},
        '{ROW_ACCESS, 1'b0, 1'b0, '{ACT_READ,  14'h0010, 32'h0}, '0},
        '{ROW_ACCESS, 1'b0, 1'b0, '{ACT_READ,  14'h0024, 32'h0}, '0},
        // loopback, level mode
        '{ROW_ACCESS, 1'b0, 1'b0, '{ACT_WRITE, 14'h0004, 32'h0000_0320}, '0},
        '{ROW_ACCESS, 1'b0, 1'b0, '{ACT_WRITE, 14'h0020, 32'hffff_ffff}, '0},
        '{ROW_ACCESS, 1'b0, 1'b0, '{ACT_WRITE, 14'h000c, 32'h1234_5678}, '0},
        '{ROW_ACCESS, 1'b0, 1'b0, '{ACT_READ,  14'h000c, 32'h0}, '0},
        '{ROW_ACCESS, 1'b0, 1'b0, '{ACT_READ,  14'h001c, 32'h0}, '0},
        // third channel: modem registers vanish, transmit always loops back
        '{ROW_CFG,    1'b1, 1'b0, '0, '0},
        '{ROW_ACCESS, 1'b0, 1'b1, '{ACT_READ,  14'h000c, 32'h0}, RSP_BAD},
        '{ROW_ACCESS, 1'b0, 1'b1, '{ACT_WRITE, 14'h001c, 32'hffff_ffff}, RSP_BAD},
        '{ROW_ACCESS, 1'b0, 1'b0, '{ACT_WRITE, 14'h0004, 32'h0}, '0},
        '{ROW_ACCESS, 1'b0, 1'b0, '{ACT_WRITE, 14'h0020, 32'h0000_00c3}, '0},
        '{ROW_ACCESS, 1'b0, 1'b0, '{ACT_READ,  14'h0024, 32'h0}, '0}
    };

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_ready;
    req_item_t req;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    rsp_item_t rsp;
    logic      cfg_valid;
    logic      cfg_ready;
    logic      cfg_data;

    // predictor state
    logic [31:0] bank [REG_COUNT];
    logic        third_ch;

    rsp_item_t   due_rsp_q [$];
    bit          gaps_on;
    int unsigned fail_cnt;
    int unsigned quiet_cycles;
    int unsigned n_rd, n_wr, n_bad, n_loop, n_checked;

    uart_register_block dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic rsp_item_t uart_access(req_item_t a);
        rsp_item_t       r;
        logic [11:0]     idx;
        logic [IX_W-1:0] ix;
        logic [31:0]     con;
        logic            bad;
        r   = '{32'h0, 1'b0, EV_NONE, EV_NONE};
        idx = a.reg_offset[13:2];
        ix  = idx[IX_W-1:0];
        bad = (a.reg_offset[1:0] != 2'b00) || (idx >= REG_COUNT) ||
              (third_ch && (ix == IX_MCON || ix == IX_MSTAT));
        if (bad)
        begin
            r.read_data  = '1;
            r.bad_offset = 1'b1;
            n_bad++;
        end
        else if (a.action == ACT_READ)
        begin
            if (ix == IX_RX)
            begin
                bank[IX_STAT][0] = 1'b0;
                if (bank[IX_CON][RX_LEVEL_BIT])
                    r.rx_int_event = EV_DEASSERT;
            end
            r.read_data = bank[ix];
        end
        else
        begin
            bank[ix] = a.write_data;
            if (ix == IX_CON)
            begin
                if (a.write_data[TX_LEVEL_BIT])
                    r.tx_int_event = EV_LEVEL;
                if (a.write_data[RX_LEVEL_BIT])
                    r.rx_int_event = EV_DEASSERT;
            end
            else if (ix == IX_TX)
            begin
                con = bank[IX_CON];
                bank[IX_STAT][2:1] = 2'b11;
                r.tx_int_event = con[TX_LEVEL_BIT] ? EV_LEVEL : EV_PULSE;
                if (con[LOOPBACK_BIT] || third_ch)
                begin
                    bank[IX_RX]      = a.write_data;
                    bank[IX_STAT][0] = 1'b1;
                    r.rx_int_event   = con[RX_LEVEL_BIT] ? EV_LEVEL : EV_PULSE;
                    n_loop++;
                end
            end
        end
        return r;
    endfunction

    function automatic req_item_t random_access();
        req_item_t   a;
        int unsigned pick;
        logic [3:0]  ix;
        pick         = $urandom_range(0, 99);
        ix           = 4'($urandom_range(0, REG_COUNT - 1));
        a.action     = 1'($urandom_range(0, 1));
        a.write_data = $urandom;
        if (pick < 80)
            a.reg_offset = {8'h00, ix, 2'b00};
        else if (pick < 88)
            a.reg_offset = {8'h00, ix, 2'($urandom_range(1, 3))};
        else if (pick < 94)
            a.reg_offset = {12'($urandom_range(REG_COUNT, 4095)), 2'b00};
        else
            a.reg_offset = 14'($urandom);
        return a;
    endfunction

    // Called right after a rising edge; leaves req_valid high on return.
    task automatic issue_access(input req_item_t a, input logic pinned,
                                input rsp_item_t want);
        rsp_item_t p;
        while (gaps_on && $urandom_range(0, 99) < 11)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= a;
        do
            @(posedge clk);
        while (!(req_valid && req_ready));
        p = uart_access(a);
        due_rsp_q.push_back(pinned ? want : p);
        if (a.action == ACT_WRITE)
            n_wr++;
        else
            n_rd++;
    endtask

    task automatic set_channel(input logic sel);
        req_valid <= 1'b0;
        while (due_rsp_q.size() != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= sel;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        third_ch = sel;
        cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string fname, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s expected %h, got %h", $time, fname, want_v, got_v);
            fail_cnt++;
        end
    endtask

    always @(posedge clk)
    begin : rsp_check
        rsp_item_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (due_rsp_q.size() == 0)
            begin
                $display("%0t: response with no request outstanding, expected none, got %h",
                         $time, rsp);
                fail_cnt++;
            end
            else
            begin
                want = due_rsp_q.pop_front();
                n_checked++;
                check_field("read_data", want.read_data, rsp.read_data);
                check_field("bad_offset", 32'(want.bad_offset), 32'(rsp.bad_offset));
                check_field("tx_int_event", 32'(want.tx_int_event), 32'(rsp.tx_int_event));
                check_field("rx_int_event", 32'(want.rx_int_event), 32'(rsp.rx_int_event));
            end
        end
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("uart_register_block verification failed");
            $finish;
        end
    end

    always @(posedge clk)
        rsp_ready <= !gaps_on || ($urandom_range(0, 99) >= 11);

    initial
    begin : stimulus
        int unsigned  ph_items;
        req_item_t    a;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        cfg_valid = 1'b0;
        cfg_data  = 1'b0;
        gaps_on   = 1'b1;
        third_ch  = 1'b0;
        foreach (bank[k])
            bank[k] = '0;
        bank[IX_STAT] = STATUS_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (PLAN[i])
        begin
            if (PLAN[i].kind == ROW_CFG)
                set_channel(PLAN[i].cfg_val);
            else
                issue_access(PLAN[i].acc, PLAN[i].pinned, PLAN[i].want);
        end

        // channel select alternates 0,1,0,1; third phase runs without gaps
        for (int ph = 0; ph < 4; ph++)
        begin
            set_channel(ph[0]);
            gaps_on  = (ph != 2);
            ph_items = 0;
            while (ph_items < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    // transmit then drain receive, exercises loopback path
                    a = '{ACT_WRITE, {8'h00, IX_TX, 2'b00}, 32'($urandom)};
                    issue_access(a, 1'b0, '0);
                    a = '{ACT_READ, {8'h00, IX_RX, 2'b00}, 32'($urandom)};
                    issue_access(a, 1'b0, '0);
                    ph_items += 2;
                end
                else
                begin
                    issue_access(random_access(), 1'b0, '0);
                    ph_items++;
                end
            end
        end
        req_valid <= 1'b0;
        gaps_on = 1'b1;

        while (due_rsp_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("covered %0d reads and %0d writes, %0d to bad offsets, %0d loopback transmits",
                 n_rd, n_wr, n_bad, n_loop);
        $display("%0d responses checked over both channel settings", n_checked);
        if (fail_cnt == 0)
            $display("uart_register_block verification clean");
        else
            $display("uart_register_block verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/urb_pkg.sv
rtl/urb_ctrl.sv
rtl/urb_datapath.sv
rtl/uart_register_block.sv
sim/tb_top.sv
